// ===== hw/rtl/nnpc_pkg.sv =====
// Shared constants and types of the nearest-neighbor point chainer.
`default_nettype none

package nnpc_pkg;

  // Default sizing
  localparam int MAX_POINTS_DEF = 64;
  localparam int COORD_BITS_DEF = 16;

  // Sets below this size pass through in load order
  localparam int SHORT_SET = 3;

  // Width of the source index field on the result channel
  localparam int SRC_BITS = 6;

  // Tag of one operand pair handed to the distance unit
  typedef struct packed {
    logic vld;   // pair is present
    logic chk;   // start-to-best test instead of a scan candidate
    logic free;  // candidate is still unused
  } dist_req_t;

endpackage

`default_nettype wire

// ===== hw/rtl/nnpc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module nnpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire                          clk,
  input  wire                          we,
  input  wire  [$clog2(DEPTH)-1:0]     waddr,
  input  wire  [WIDTH-1:0]             wdata,
  input  wire  [$clog2(DEPTH)-1:0]     raddr,
  output logic [WIDTH-1:0]             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== hw/rtl/nnpc_dist.sv =====
// Pipelined squared-distance unit with running nearest-candidate tracking.
`default_nettype none

module nnpc_dist
  import nnpc_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int IDX_BITS   = 6
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire  dist_req_t            req,       // tag, issued with the RAM read
  input  wire  [IDX_BITS-1:0]        req_idx,
  input  wire                        clear,     // start of a new scan
  input  wire  [COORD_BITS-1:0]      cand_x,    // RAM read data, in the cycle after req
  input  wire  [COORD_BITS-1:0]      cand_y,
  input  wire  [COORD_BITS-1:0]      cur_x,
  input  wire  [COORD_BITS-1:0]      cur_y,
  input  wire  [COORD_BITS-1:0]      start_x,
  input  wire  [COORD_BITS-1:0]      start_y,
  output logic                       busy,
  output logic [IDX_BITS-1:0]        best_idx,
  output logic [COORD_BITS-1:0]      best_x,
  output logic [COORD_BITS-1:0]      best_y,
  output logic [2*COORD_BITS+2:0]    best_d,
  output logic [2*COORD_BITS+2:0]    chk_d
);

  localparam int AW = COORD_BITS + 1;
  localparam int QW = 2 * COORD_BITS + 2;
  localparam int DW = 2 * COORD_BITS + 3;

  dist_req_t                s0_r, s1_r, s2_r;
  logic [IDX_BITS-1:0]      s0_idx_r, s1_idx_r, s2_idx_r;
  logic [COORD_BITS-1:0]    s1_x_r, s1_y_r, s2_x_r, s2_y_r;
  logic [AW-1:0]            s1_ax_r, s1_ay_r;
  logic [QW-1:0]            s2_qx_r, s2_qy_r;

  logic                     found_r;
  logic [IDX_BITS-1:0]      best_idx_r;
  logic [COORD_BITS-1:0]    best_x_r, best_y_r;
  logic [DW-1:0]            best_d_r, chk_d_r;

  logic [COORD_BITS-1:0]    sx_w, sy_w, rx_w, ry_w;
  logic signed [AW-1:0]     dx_w, dy_w;
  logic [AW-1:0]            ax_w, ay_w;
  logic [DW-1:0]            sum_w;
  logic                     take_w;

  // Operand select and absolute differences
  always_comb begin
    sx_w = s0_r.chk ? best_x_r : cand_x;
    sy_w = s0_r.chk ? best_y_r : cand_y;
    rx_w = s0_r.chk ? start_x  : cur_x;
    ry_w = s0_r.chk ? start_y  : cur_y;
    dx_w = $signed({sx_w[COORD_BITS-1], sx_w}) - $signed({rx_w[COORD_BITS-1], rx_w});
    dy_w = $signed({sy_w[COORD_BITS-1], sy_w}) - $signed({ry_w[COORD_BITS-1], ry_w});
    ax_w = dx_w[AW-1] ? $unsigned(-dx_w) : $unsigned(dx_w);
    ay_w = dy_w[AW-1] ? $unsigned(-dy_w) : $unsigned(dy_w);
  end

  // Sum of squares and strict-less compare; first hit wins ties
  assign sum_w  = DW'(s2_qx_r) + DW'(s2_qy_r);
  assign take_w = s2_r.vld && !s2_r.chk && s2_r.free && (!found_r || (sum_w < best_d_r));

  // Pipeline tags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_r    <= '0;
      s1_r    <= '0;
      s2_r    <= '0;
      found_r <= 1'b0;
    end else begin
      s0_r <= req;
      s1_r <= s0_r;
      s2_r <= s1_r;
      if (clear) begin
        found_r <= 1'b0;
      end else if (take_w) begin
        found_r <= 1'b1;
      end
    end
  end

  // Pipeline payload and result registers
  always_ff @(posedge clk) begin
    s0_idx_r <= req_idx;
    s1_idx_r <= s0_idx_r;
    s1_x_r   <= sx_w;
    s1_y_r   <= sy_w;
    s1_ax_r  <= ax_w;
    s1_ay_r  <= ay_w;
    s2_idx_r <= s1_idx_r;
    s2_x_r   <= s1_x_r;
    s2_y_r   <= s1_y_r;
    s2_qx_r  <= QW'(s1_ax_r) * QW'(s1_ax_r);
    s2_qy_r  <= QW'(s1_ay_r) * QW'(s1_ay_r);
    if (take_w) begin
      best_idx_r <= s2_idx_r;
      best_x_r   <= s2_x_r;
      best_y_r   <= s2_y_r;
      best_d_r   <= sum_w;
    end
    if (s2_r.vld && s2_r.chk) begin
      chk_d_r <= sum_w;
    end
  end

  assign busy     = s0_r.vld | s1_r.vld | s2_r.vld;
  assign best_idx = best_idx_r;
  assign best_x   = best_x_r;
  assign best_y   = best_y_r;
  assign best_d   = best_d_r;
  assign chk_d    = chk_d_r;

endmodule

`default_nettype wire

// ===== hw/rtl/nearest_neighbor_point_chainer.sv =====
// Top level: point load, chaining sequencer and ordered point output.
//
// Usage: points stream in on in_* one per transfer; in_tlast marks the last
// point of a set and starts ordering. Up to MAX_POINTS points are kept, later
// ones of the same set are dropped. in_tready is high only while loading.
// After the final point the block chains the set greedily by nearest unused
// neighbor, then sends every point on out_* in chained order, out_tlast on
// the last one. Sets of one or two points come out in load order.
// Ordering: each chained point costs one scan of the n stored points through
// the shared distance unit, plus a start-point test while the tail grows; the
// ordering is bounded by the single point-RAM read port. Output goes one point
// at a time: each passes through S_ORD, S_ORD2 and S_PTW, then waits in S_SEND
// while out_tready is low; the result register holds its transfer stable
// during a stall.
// Reset (rst_n low, synchronous) empties the point set and returns to loading.
`default_nettype none

module nearest_neighbor_point_chainer
  import nnpc_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire                                        clk,
  input  wire                                        rst_n,
  input  wire                                        in_tvalid,
  output logic                                       in_tready,
  // point_x, point_y
  input  wire  [((2*COORD_BITS+7)/8)*8-1:0]          in_tdata,
  // final_point
  input  wire                                        in_tlast,
  output logic                                       out_tvalid,
  input  wire                                        out_tready,
  // out_x, out_y, source_index
  output logic [((2*COORD_BITS+SRC_BITS+7)/8)*8-1:0] out_tdata,
  // end_of_line
  output logic                                       out_tlast
);

  localparam int C     = COORD_BITS;
  localparam int IW    = $clog2(MAX_POINTS);
  localparam int CW    = $clog2(MAX_POINTS + 1);
  localparam int DW    = 2 * COORD_BITS + 3;
  localparam int OUT_W = ((2*COORD_BITS+SRC_BITS+7)/8)*8;

  typedef enum logic [9:0] {
    S_LOAD   = 10'b0000000001,
    S_INIT   = 10'b0000000010,
    S_SCAN   = 10'b0000000100,
    S_DRAIN  = 10'b0000001000,
    S_TEST   = 10'b0000010000,
    S_DECIDE = 10'b0000100000,
    S_ORD    = 10'b0001000000,
    S_ORD2   = 10'b0010000000,
    S_PTW    = 10'b0100000000,
    S_SEND   = 10'b1000000000
  } state_t;

  typedef enum logic [2:0] {
    PH_FIRST = 3'b001,
    PH_TAIL  = 3'b010,
    PH_HEAD  = 3'b100
  } phase_t;

  state_t                state_r, state_nxt;
  phase_t                phase_r, phase_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [CW-1:0]         remain_r, remain_nxt;
  logic [IW-1:0]         head_r, head_nxt;
  logic [IW-1:0]         tail_r, tail_nxt;
  logic [IW-1:0]         scan_r, scan_nxt;
  logic [IW-1:0]         out_cnt_r, out_cnt_nxt;
  logic [MAX_POINTS-1:0] used_r, used_nxt;
  logic                  short_r, short_nxt;
  logic [C-1:0]          start_x_r, start_y_r;
  logic [C-1:0]          cur_x_r, cur_y_r, cur_x_nxt, cur_y_nxt;
  logic [C-1:0]          out_x_r, out_y_r;
  logic [IW-1:0]         out_src_r;
  logic                  out_last_r;

  logic                  in_xfer_w;
  logic                  store_w;
  logic [CW-1:0]         n_m1_w;
  logic [IW-1:0]         src_sel_w;
  logic                  prepend_w;

  // RAM and distance unit hookup
  logic                  pt_we;
  logic [IW-1:0]         pt_raddr;
  logic [2*C-1:0]        pt_rdata;
  logic                  ring_we;
  logic [IW-1:0]         ring_waddr;
  logic [IW-1:0]         ring_wdata;
  logic [IW-1:0]         ring_raddr;
  logic [IW-1:0]         ring_rdata;
  dist_req_t             req;
  logic                  dist_clear;
  logic                  busy;
  logic [IW-1:0]         best_idx;
  logic [C-1:0]          best_x, best_y;
  logic [DW-1:0]         best_d, chk_d;

  assign in_tready = (state_r == S_LOAD);
  assign in_xfer_w = in_tvalid && in_tready;
  assign store_w   = in_xfer_w && (cnt_r < CW'(MAX_POINTS));
  assign n_m1_w    = cnt_r - CW'(1);
  assign src_sel_w = short_r ? out_cnt_r : ring_rdata;
  assign prepend_w = (phase_r == PH_HEAD) || ((phase_r == PH_TAIL) && (chk_d < best_d));

  // Point store: loads write, scans and output read
  assign pt_we      = store_w;
  assign pt_raddr   = (state_r == S_SCAN) ? scan_r : src_sel_w;
  assign ring_raddr = head_r + out_cnt_r;

  nnpc_ram #(
    .WIDTH (2 * C),
    .DEPTH (MAX_POINTS)
  ) u_pt_ram (
    .clk   (clk),
    .we    (pt_we),
    .waddr (cnt_r[IW-1:0]),
    .wdata ({in_tdata[2*C-1:C], in_tdata[C-1:0]}),
    .raddr (pt_raddr),
    .rdata (pt_rdata)
  );

  nnpc_ram #(
    .WIDTH (IW),
    .DEPTH (2 ** IW)
  ) u_ring_ram (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_waddr),
    .wdata (ring_wdata),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

  nnpc_dist #(
    .COORD_BITS (C),
    .IDX_BITS   (IW)
  ) u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req),
    .req_idx  (scan_r),
    .clear    (dist_clear),
    .cand_x   (pt_rdata[C-1:0]),
    .cand_y   (pt_rdata[2*C-1:C]),
    .cur_x    (cur_x_r),
    .cur_y    (cur_y_r),
    .start_x  (start_x_r),
    .start_y  (start_y_r),
    .busy     (busy),
    .best_idx (best_idx),
    .best_x   (best_x),
    .best_y   (best_y),
    .best_d   (best_d),
    .chk_d    (chk_d)
  );

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    phase_nxt   = phase_r;
    cnt_nxt     = cnt_r;
    remain_nxt  = remain_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    scan_nxt    = scan_r;
    out_cnt_nxt = out_cnt_r;
    used_nxt    = used_r;
    short_nxt   = short_r;
    cur_x_nxt   = cur_x_r;
    cur_y_nxt   = cur_y_r;
    ring_we     = 1'b0;
    ring_waddr  = head_r;
    ring_wdata  = best_idx;
    req         = '0;
    dist_clear  = 1'b0;

    case (state_r)
      S_LOAD: begin
        if (store_w) begin
          cnt_nxt = cnt_r + CW'(1);
        end
        if (in_xfer_w && in_tlast) begin
          state_nxt = S_INIT;
        end
      end

      S_INIT: begin
        head_nxt    = '0;
        tail_nxt    = '0;
        ring_we     = 1'b1;
        ring_waddr  = '0;
        ring_wdata  = '0;
        used_nxt    = '0;
        used_nxt[0] = 1'b1;
        cur_x_nxt   = start_x_r;
        cur_y_nxt   = start_y_r;
        phase_nxt   = PH_FIRST;
        short_nxt   = (cnt_r < CW'(SHORT_SET));
        scan_nxt    = '0;
        out_cnt_nxt = '0;
        if (cnt_r < CW'(SHORT_SET)) begin
          state_nxt = S_ORD;
        end else begin
          dist_clear = 1'b1;
          state_nxt  = S_SCAN;
        end
      end

      // one stored point per cycle into the distance unit
      S_SCAN: begin
        req.vld  = 1'b1;
        req.free = !used_r[scan_r];
        if (scan_r == n_m1_w[IW-1:0]) begin
          state_nxt = S_DRAIN;
        end else begin
          scan_nxt = scan_r + IW'(1);
        end
      end

      S_DRAIN: begin
        if (!busy) begin
          if (phase_r == PH_TAIL) begin
            req.vld   = 1'b1;
            req.chk   = 1'b1;
            state_nxt = S_TEST;
          end else begin
            state_nxt = S_DECIDE;
          end
        end
      end

      S_TEST: begin
        if (!busy) begin
          state_nxt = S_DECIDE;
        end
      end

      // put the nearest point at the tail or the head of the chain
      S_DECIDE: begin
        ring_we            = 1'b1;
        used_nxt[best_idx] = 1'b1;
        cur_x_nxt          = best_x;
        cur_y_nxt          = best_y;
        if (prepend_w) begin
          head_nxt   = head_r - IW'(1);
          ring_waddr = head_r - IW'(1);
          phase_nxt  = PH_HEAD;
        end else begin
          tail_nxt   = tail_r + IW'(1);
          ring_waddr = tail_r + IW'(1);
          phase_nxt  = PH_TAIL;
        end
        if (phase_r == PH_FIRST) begin
          remain_nxt = cnt_r - CW'(2);
        end else begin
          remain_nxt = remain_r - CW'(1);
        end
        scan_nxt    = '0;
        out_cnt_nxt = '0;
        if (remain_nxt == '0) begin
          state_nxt = S_ORD;
        end else begin
          dist_clear = 1'b1;
          state_nxt  = S_SCAN;
        end
      end

      S_ORD: begin
        state_nxt = S_ORD2;
      end

      S_ORD2: begin
        state_nxt = S_PTW;
      end

      S_PTW: begin
        state_nxt = S_SEND;
      end

      S_SEND: begin
        if (out_tready) begin
          if (out_last_r) begin
            cnt_nxt   = '0;
            used_nxt  = '0;
            state_nxt = S_LOAD;
          end else begin
            out_cnt_nxt = out_cnt_r + IW'(1);
            state_nxt   = S_ORD;
          end
        end
      end

      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_LOAD;
      phase_r   <= PH_FIRST;
      cnt_r     <= '0;
      remain_r  <= '0;
      head_r    <= '0;
      tail_r    <= '0;
      scan_r    <= '0;
      out_cnt_r <= '0;
      used_r    <= '0;
      short_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      phase_r   <= phase_nxt;
      cnt_r     <= cnt_nxt;
      remain_r  <= remain_nxt;
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      scan_r    <= scan_nxt;
      out_cnt_r <= out_cnt_nxt;
      used_r    <= used_nxt;
      short_r   <= short_nxt;
    end
  end

  // Coordinate and result registers
  always_ff @(posedge clk) begin
    if (in_xfer_w && (cnt_r == '0)) begin
      start_x_r <= in_tdata[C-1:0];
      start_y_r <= in_tdata[2*C-1:C];
    end
    cur_x_r <= cur_x_nxt;
    cur_y_r <= cur_y_nxt;
    if (state_r == S_ORD2) begin
      out_src_r <= src_sel_w;
    end
    if (state_r == S_PTW) begin
      out_x_r    <= pt_rdata[C-1:0];
      out_y_r    <= pt_rdata[2*C-1:C];
      out_last_r <= (out_cnt_r == n_m1_w[IW-1:0]);
    end
  end

  assign out_tvalid = (state_r == S_SEND);
  assign out_tdata  = OUT_W'({SRC_BITS'(out_src_r), out_y_r, out_x_r});
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Testbench of the nearest-neighbor point chainer: directed and random point sets, predicted order, checks.
`default_nettype none

module testbench;
  import nnpc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPTS       = MAX_POINTS_DEF;
  localparam int IN_W       = ((2*COORD_BITS_DEF+7)/8)*8;
  localparam int OUT_W      = ((2*COORD_BITS_DEF+SRC_BITS+7)/8)*8;
  localparam int IDLE_LIMIT = 40000;
  localparam int DRAIN_WAIT = 60;
  localparam int RAND_ITEMS = 450;
  localparam int MAX_PRINTS = 40;

  typedef enum int {SPREAD, CLUSTER, CORNERS, GRID} coord_mode_e;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    bit                 last;
  } point_t;

  typedef struct {
    logic signed [15:0]    x;
    logic signed [15:0]    y;
    bit [SRC_BITS-1:0]     src;
    bit                    eol;
  } chained_pt_t;

  // DUT signals
  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  logic             in_tlast = 1'b0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic             out_tlast;

  nearest_neighbor_point_chainer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Stimulus and bookkeeping
  point_t      pending_points[$];
  chained_pt_t expected_order[$];
  int          total_items;
  int          accepted_items;
  int          checked_points;
  int          sets_ordered;
  int          dropped_points;
  int          errors;
  int          idle_cycles;
  bit          in_fire;
  bit          calm;
  int          burst_left;
  int          gap_left;
  int          stall_left;
  int          phase_cnt;

  // Predictor state: the current point set
  logic signed [15:0] set_x[NPTS];
  logic signed [15:0] set_y[NPTS];
  bit                 used_mark[NPTS];
  int                 set_count;

  task automatic report_mismatch(string msg);
    errors++;
    if (errors <= MAX_PRINTS)
      $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  function automatic longint unsigned sq_dist(int a, int b);
    longint dx;
    longint dy;
    dx = longint'(set_x[a]) - longint'(set_x[b]);
    dy = longint'(set_y[a]) - longint'(set_y[b]);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    return longint'(dx * dx + dy * dy);
  endfunction

  // Nearest unused point to p; the lowest index wins a tie
  function automatic bit find_nearest(int p, output int idx, output longint unsigned d);
    bit              found;
    longint unsigned c;
    found = 0;
    idx = 0;
    d = 0;
    for (int i = 0; i < set_count; i++) begin
      if (!used_mark[i]) begin
        c = sq_dist(p, i);
        if (!found || c < d) begin
          found = 1;
          d = c;
          idx = i;
        end
      end
    end
    return found;
  endfunction

  // Chain the stored set and queue its points in chained order
  function automatic void emit_chain();
    bit [5:0]        order[NPTS];
    bit [5:0]        head;
    bit [5:0]        tail;
    bit [5:0]        pos;
    int              k;
    int              cur;
    int              remaining;
    longint unsigned d;
    bit              broke;
    bit              found;
    chained_pt_t     e;
    head = 0;
    tail = 0;
    order[0] = 0;
    broke = 0;
    for (int i = 0; i < NPTS; i++) used_mark[i] = 0;
    if (set_count < SHORT_SET) begin
      for (int i = 1; i < set_count; i++) begin
        tail++;
        order[tail] = i[5:0];
      end
    end else begin
      used_mark[0] = 1;
      found = find_nearest(0, k, d);
      tail++;
      order[tail] = k[5:0];
      used_mark[k] = 1;
      cur = k;
      remaining = set_count - 2;
      // grow at the tail until the start point is the closer end
      while (remaining > 0) begin
        found = find_nearest(cur, k, d);
        if (!found) break;
        if (sq_dist(0, k) < d) begin
          broke = 1;
          break;
        end
        tail++;
        order[tail] = k[5:0];
        used_mark[k] = 1;
        cur = k;
        remaining--;
      end
      // then grow at the head over what is left
      if (broke) begin
        head--;
        order[head] = k[5:0];
        used_mark[k] = 1;
        cur = k;
        remaining--;
        while (remaining > 0) begin
          found = find_nearest(cur, k, d);
          if (!found) break;
          head--;
          order[head] = k[5:0];
          used_mark[k] = 1;
          cur = k;
          remaining--;
        end
      end
    end
    for (int i = 0; i < set_count; i++) begin
      pos = head + i[5:0];
      e.src = order[pos];
      e.x = set_x[e.src];
      e.y = set_y[e.src];
      e.eol = (i + 1 == set_count);
      expected_order.push_back(e);
    end
    set_count = 0;
    for (int i = 0; i < NPTS; i++) used_mark[i] = 0;
  endfunction

  function automatic void load_point(logic signed [15:0] x, logic signed [15:0] y, bit last);
    if (set_count < NPTS) begin
      set_x[set_count] = x;
      set_y[set_count] = y;
      used_mark[set_count] = 0;
      set_count++;
    end else begin
      dropped_points++;
    end
    if (last) begin
      emit_chain();
      sets_ordered++;
    end
  endfunction

  task automatic add_point(logic signed [15:0] x, logic signed [15:0] y, bit last);
    point_t p;
    p.x = x;
    p.y = y;
    p.last = last;
    pending_points.push_back(p);
  endtask

  function automatic logic signed [15:0] pick_coord(coord_mode_e mode, logic signed [15:0] base);
    logic signed [15:0] v;
    case (mode)
      SPREAD:  v = 16'($urandom);
      CLUSTER: v = base + 16'($urandom_range(0, 64)) - 16'sd32;
      CORNERS: begin
        case ($urandom_range(0, 3))
          0:       v = -16'sd32768;
          1:       v = 16'sd32767;
          2:       v = 16'sd0;
          default: v = -16'sd1;
        endcase
      end
      default: v = 16'($urandom_range(0, 7));
    endcase
    return v;
  endfunction

  // Monitor: transfers on both channels, sampled at the rising edge
  always @(posedge clk) begin
    chained_pt_t e;
    bit          out_fire;
    in_fire = rst_n && in_tvalid && in_tready;
    out_fire = rst_n && out_tvalid && out_tready;
    if (in_fire) begin
      accepted_items++;
      load_point(in_tdata[15:0], in_tdata[31:16], in_tlast);
    end
    if (out_fire) begin
      if (expected_order.size() == 0) begin
        report_mismatch($sformatf("unexpected result x=%0d y=%0d src=%0d",
                                  $signed(out_tdata[15:0]), $signed(out_tdata[31:16]),
                                  out_tdata[37:32]));
      end else begin
        e = expected_order.pop_front();
        checked_points++;
        if (out_tdata[15:0] !== e.x)
          report_mismatch($sformatf("out_x %0d, expected %0d (src %0d)",
                                    $signed(out_tdata[15:0]), e.x, e.src));
        if (out_tdata[31:16] !== e.y)
          report_mismatch($sformatf("out_y %0d, expected %0d (src %0d)",
                                    $signed(out_tdata[31:16]), e.y, e.src));
        if (out_tdata[37:32] !== e.src)
          report_mismatch($sformatf("source_index %0d, expected %0d",
                                    out_tdata[37:32], e.src));
        if (out_tlast !== e.eol)
          report_mismatch($sformatf("end_of_line %b, expected %b (src %0d)",
                                    out_tlast, e.eol, e.src));
      end
    end
    if (in_fire || out_fire) idle_cycles = 0;
    else if (rst_n) idle_cycles++;
  end

  // Driver: points from the pending queue, in bursts with gaps
  always @(negedge clk) begin
    point_t p;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!(in_tvalid && !in_fire)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (pending_points.size() > 0) begin
        p = pending_points.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= {p.y, p.x};
        in_tlast <= p.last;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 16);
          gap_left = (calm || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, with calm stretches that are redrawn periodically
  always @(negedge clk) begin
    phase_cnt++;
    if (phase_cnt % 300 == 0) calm = ($urandom_range(0, 2) == 0);
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      stall_left = $urandom_range(0, 6);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  initial begin
    coord_mode_e        mode;
    logic signed [15:0] bx;
    logic signed [15:0] by;
    int                 sz;
    int                 rnd_items;
    bit                 timed_out;

    // Directed: single point at the extremes
    add_point(-16'sd32768, 16'sd32767, 1);
    // Two points pass through in load order
    add_point(16'sd32767, -16'sd32768, 0);
    add_point(16'sd0, 16'sd0, 1);
    // Tie at the start goes to the lower index, then the start end is closer
    add_point(16'sd0, 16'sd0, 0);
    add_point(16'sd10, 16'sd0, 0);
    add_point(-16'sd10, 16'sd0, 1);
    // Straight line, tail growth only
    add_point(16'sd0, 16'sd0, 0);
    add_point(16'sd1, 16'sd0, 0);
    add_point(16'sd3, 16'sd0, 0);
    add_point(16'sd6, 16'sd0, 1);
    // Coincident points
    add_point(16'sd5, 16'sd5, 0);
    add_point(16'sd5, 16'sd5, 0);
    add_point(16'sd5, 16'sd5, 0);
    add_point(-16'sd1, -16'sd1, 0);
    add_point(16'sd5, 16'sd5, 1);
    // Corners: largest distances
    add_point(-16'sd32768, -16'sd32768, 0);
    add_point(16'sd32767, 16'sd32767, 0);
    add_point(-16'sd32768, 16'sd32767, 0);
    add_point(16'sd32767, -16'sd32768, 0);
    add_point(16'sd0, 16'sd0, 0);
    add_point(-16'sd1, -16'sd1, 1);

    // Random sets: mostly small, a few large ones that can fill the store and overflow it
    rnd_items = 0;
    sz = 66;
    while (rnd_items < RAND_ITEMS) begin
      mode = coord_mode_e'($urandom_range(0, 3));
      bx = 16'($urandom);
      by = 16'($urandom);
      for (int j = 0; j < sz; j++)
        add_point(pick_coord(mode, bx), pick_coord(mode, by), j == sz - 1);
      rnd_items += sz;
      if ($urandom_range(0, 9) == 0) sz = $urandom_range(60, 70);
      else sz = $urandom_range(1, 12);
    end
    total_items = pending_points.size();

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    timed_out = 0;
    while (!(accepted_items == total_items && expected_order.size() == 0)) begin
      @(posedge clk);
      if (idle_cycles >= IDLE_LIMIT) begin
        timed_out = 1;
        break;
      end
    end
    if (!timed_out) repeat (DRAIN_WAIT) @(posedge clk);
    if (timed_out)
      report_mismatch($sformatf("watchdog: %0d cycles without a transfer", IDLE_LIMIT));
    if (expected_order.size() != 0)
      report_mismatch($sformatf("%0d chained points never came out", expected_order.size()));

    $display("Run: %0d of %0d points loaded in %0d sets, %0d past a full store",
             accepted_items, total_items, sets_ordered, dropped_points);
    $display("Run: %0d chained points checked, %0d errors", checked_points, errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
